FILE: hdl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP status line parser package
// Byte classes, queue item and result types, and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hsp_pkg;

  localparam int MAX_BUFFER_BYTES_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF      = 4;
  localparam int REASON_START         = 13;

  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_H,
    CLS_T,
    CLS_P,
    CLS_SLASH,
    CLS_DOT,
    CLS_SPACE,
    CLS_CR,
    CLS_LF,
    CLS_DIGIT
  } hsp_class_t;

  typedef struct packed {
    hsp_class_t  cls;
    logic [3:0]  digit;
    logic        last;
  } hsp_item_t;

  typedef struct packed {
    logic [11:0] headers_length;
    logic [12:0] headers_offset;
    logic [11:0] reason_length;
    logic [9:0]  resp_code;
    logic        ok;
  } hsp_result_t;

endpackage

`default_nettype wire

FILE: hdl/hsp_queue.sv
// ----------------------------------------------------------------------------
// HTTP status line parser queue
// Small flip-flop FIFO between the classifier and the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_queue #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hsp_front.sv
// ----------------------------------------------------------------------------
// HTTP status line parser front end
// Accept input bytes and classify each into a token for the parse engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_front (
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,
  input  wire logic             s_tlast,
  output logic                  push,
  output hsp_pkg::hsp_item_t    push_item,
  input  wire logic             queue_full
);

  import hsp_pkg::*;

  hsp_class_t cls;

  always_comb begin
    case (s_tdata)
      CHAR_H:     cls = CLS_H;
      CHAR_T:     cls = CLS_T;
      CHAR_P:     cls = CLS_P;
      CHAR_SLASH: cls = CLS_SLASH;
      CHAR_DOT:   cls = CLS_DOT;
      CHAR_SPACE: cls = CLS_SPACE;
      CHAR_CR:    cls = CLS_CR;
      CHAR_LF:    cls = CLS_LF;
      default: begin
        if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
          cls = CLS_DIGIT;
        end else begin
          cls = CLS_OTHER;
        end
      end
    endcase
  end

  assign s_tready        = !queue_full;
  assign push            = s_tvalid && !queue_full;
  assign push_item.cls   = cls;
  assign push_item.digit = s_tdata[3:0];
  assign push_item.last  = s_tlast;

endmodule

`default_nettype wire

FILE: hdl/hsp_back.sv
// ----------------------------------------------------------------------------
// HTTP status line parser engine
// Walk the status line phases over classified items and build the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_back #(
  parameter int MAX_BUFFER_BYTES = hsp_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  hsp_pkg::hsp_item_t      item,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output hsp_pkg::hsp_result_t    result
);

  import hsp_pkg::*;

  localparam int POS_W  = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int CALC_W = (POS_W > 13) ? POS_W : 13;

  typedef enum logic [5:0] {
    PH_PREFIX  = 6'b000001,
    PH_VERSION = 6'b000010,
    PH_CODE    = 6'b000100,
    PH_REASON  = 6'b001000,
    PH_LF      = 6'b010000,
    PH_HEADERS = 6'b100000
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [POS_W-1:0]  position;
  logic [9:0]        code_acc;
  logic [9:0]        code_acc_next;
  logic [POS_W-1:0]  line_end;
  logic [POS_W-1:0]  line_end_next;
  logic              failed;
  logic              failed_next;
  logic              slot_free;
  logic              parse_ok;
  logic [CALC_W-1:0] hoff;
  logic [CALC_W-1:0] rlen;
  logic [CALC_W-1:0] hlen;

  assign slot_free = !m_tvalid || m_tready;
  assign pop       = item_valid && (!item.last || slot_free);

  always_comb begin
    phase_next    = phase;
    code_acc_next = code_acc;
    line_end_next = line_end;
    failed_next   = failed || (position == POS_W'(MAX_BUFFER_BYTES));
    if (!failed_next) begin
      case (phase)
        PH_PREFIX: begin
          if (position == POS_W'(0)) begin
            failed_next = (item.cls != CLS_H);
          end else if (position == POS_W'(1) || position == POS_W'(2)) begin
            failed_next = (item.cls != CLS_T);
          end else if (position == POS_W'(3)) begin
            failed_next = (item.cls != CLS_P);
          end else if (position == POS_W'(4)) begin
            failed_next = (item.cls != CLS_SLASH);
            phase_next  = PH_VERSION;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_VERSION: begin
          if (position == POS_W'(5) || position == POS_W'(7)) begin
            failed_next = (item.cls != CLS_DIGIT);
          end else if (position == POS_W'(6)) begin
            failed_next = (item.cls != CLS_DOT);
          end else if (position == POS_W'(8)) begin
            failed_next = (item.cls != CLS_SPACE);
            phase_next  = PH_CODE;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_CODE: begin
          if (position == POS_W'(9) || position == POS_W'(10) || position == POS_W'(11)) begin
            failed_next   = (item.cls != CLS_DIGIT);
            code_acc_next = {code_acc[6:0], 3'b000} + {code_acc[8:0], 1'b0}
                            + {6'd0, item.digit};
          end else if (position == POS_W'(12)) begin
            failed_next = (item.cls != CLS_SPACE);
            phase_next  = PH_REASON;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_REASON: begin
          if (item.cls == CLS_CR) begin
            line_end_next = position;
            phase_next    = PH_LF;
          end
        end
        PH_LF: begin
          failed_next = (item.cls != CLS_LF);
          phase_next  = PH_HEADERS;
        end
        PH_HEADERS: begin
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  assign parse_ok = !failed_next && (phase_next == PH_HEADERS);
  assign hoff     = CALC_W'(line_end) + CALC_W'(2);
  assign rlen     = CALC_W'(line_end) - CALC_W'(REASON_START);
  assign hlen     = CALC_W'(position) + CALC_W'(1) - hoff;

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      result.ok             <= parse_ok;
      result.resp_code      <= parse_ok ? code_acc_next : '0;
      result.reason_length  <= parse_ok ? rlen[11:0] : '0;
      result.headers_offset <= parse_ok ? hoff[12:0] : '0;
      result.headers_length <= parse_ok ? hlen[11:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PREFIX;
      position <= '0;
      code_acc <= '0;
      line_end <= '0;
      failed   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop && item.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (item.last) begin
          phase    <= PH_PREFIX;
          position <= '0;
          code_acc <= '0;
          line_end <= '0;
          failed   <= 1'b0;
        end else begin
          phase    <= phase_next;
          code_acc <= code_acc_next;
          line_end <= line_end_next;
          failed   <= failed_next;
          if (position != POS_W'(MAX_BUFFER_BYTES)) begin
            position <= position + POS_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/http_status_line_parser.sv
// ----------------------------------------------------------------------------
// HTTP status line parser
// Stream a response buffer in byte by byte and report its status line.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle on the input stream while the queue has
// room, and tlast marks the final byte of a buffer. A classifier turns each
// byte into a token, a queue of QUEUE_DEPTH tokens holds them, and the parse
// engine consumes one token per cycle, so the sustained rate is one byte per
// cycle; the engine's single output register is the only point that can hold
// a buffer's last token back. The result of a buffer is registered after its
// last token leaves the queue, and stays until taken. Buffers longer than
// MAX_BUFFER_BYTES report a failed parse.
`default_nettype none

module http_status_line_parser #(
  parameter int MAX_BUFFER_BYTES = hsp_pkg::MAX_BUFFER_BYTES_DEF,
  parameter int QUEUE_DEPTH      = hsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [0] ok, [10:1] resp_code,
                                      // [22:11] reason_length,
                                      // [35:23] headers_offset,
                                      // [47:36] headers_length
);

  import hsp_pkg::*;

  localparam int ITEM_W = $bits(hsp_item_t);

  logic        push;
  hsp_item_t   push_item;
  logic        queue_full;
  logic        pop;
  hsp_item_t   pop_item;
  logic        queue_valid;
  hsp_result_t result;

  hsp_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  hsp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_item),
    .not_empty (queue_valid)
  );

  hsp_back #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item       (pop_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = result;

endmodule

`default_nettype wire

FILE: hdl/hsp_checker.sv
// ----------------------------------------------------------------------------
// HTTP status line parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[47:1] == 47'd0)
    else $error("failed parse with nonzero fields");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[10:1] <= 10'd999)
    else $error("status code out of range");

  a_offsets: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[34:23] == 12'(m_tdata[22:11] + 12'd15))
    else $error("headers offset does not follow reason length");

endmodule

bind http_status_line_parser hsp_checker u_hsp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/hsp_tb_pkg.sv
// ----------------------------------------------------------------------------
// HTTP status line parser scoreboard
// Predicts the one result of each response buffer from its bytes as they are
// accepted, queues it, and checks the results that the parser delivers.
// ----------------------------------------------------------------------------

package hsp_tb_pkg;

  import hsp_pkg::*;

  typedef enum logic [2:0] {
    SCAN_NAME,
    SCAN_VERSION,
    SCAN_CODE,
    SCAN_REASON,
    SCAN_LF,
    SCAN_HEADERS
  } scan_phase_t;

  class status_line_scoreboard;
    hsp_result_t  expected_q[$];
    int           errors;
    int unsigned  limit_bytes;
    logic [7:0]   name_chars[5];
    scan_phase_t  scan_phase;
    int unsigned  position;
    logic [9:0]   code_acc;
    int unsigned  cr_offset;
    bit           failed;

    function new(int unsigned max_bytes);
      limit_bytes = max_bytes;
      name_chars  = '{CHAR_H, CHAR_T, CHAR_T, CHAR_P, CHAR_SLASH};
      errors      = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      scan_phase = SCAN_NAME;
      position   = 0;
      code_acc   = '0;
      cr_offset  = 0;
      failed     = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      int unsigned pos;
      int unsigned k;
      hsp_result_t res;
      pos = position;
      if (pos >= limit_bytes) failed = 1'b1;
      if (!failed) begin
        case (scan_phase)
          SCAN_NAME: begin
            if (pos > 4 || b != name_chars[pos]) failed = 1'b1;
            else if (pos == 4) scan_phase = SCAN_VERSION;
          end
          SCAN_VERSION: begin
            k = pos - 5;
            if (k == 0 || k == 2) begin
              if (b < CHAR_ZERO || b > CHAR_NINE) failed = 1'b1;
            end else if (k == 1) begin
              if (b != CHAR_DOT) failed = 1'b1;
            end else if (k == 3) begin
              if (b != CHAR_SPACE) failed = 1'b1;
              else scan_phase = SCAN_CODE;
            end else begin
              failed = 1'b1;
            end
          end
          SCAN_CODE: begin
            k = pos - 9;
            if (k < 3) begin
              if (b < CHAR_ZERO || b > CHAR_NINE) failed = 1'b1;
              else code_acc = 10'(int'(code_acc) * 10 + int'(b - CHAR_ZERO));
            end else if (k == 3) begin
              if (b != CHAR_SPACE) failed = 1'b1;
              else scan_phase = SCAN_REASON;
            end else begin
              failed = 1'b1;
            end
          end
          SCAN_REASON: begin
            if (b == CHAR_CR) begin
              cr_offset  = pos;
              scan_phase = SCAN_LF;
            end
          end
          SCAN_LF: begin
            if (b != CHAR_LF) failed = 1'b1;
            else scan_phase = SCAN_HEADERS;
          end
          SCAN_HEADERS: ;
          default: failed = 1'b1;
        endcase
      end
      if (position < limit_bytes) position++;
      if (last) begin
        res = '0;
        if (!failed && scan_phase == SCAN_HEADERS) begin
          res.ok             = 1'b1;
          res.resp_code      = code_acc;
          res.reason_length  = 12'(cr_offset - REASON_START);
          res.headers_offset = 13'(cr_offset + 2);
          res.headers_length = 12'(pos + 1 - (cr_offset + 2));
        end
        expected_q.push_back(res);
        clear_scan();
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(hsp_result_t got);
      hsp_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with none expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok %0d, want %0d", got.ok, want.ok));
      if (got.resp_code !== want.resp_code)
        report($sformatf("resp_code %0d, want %0d", got.resp_code, want.resp_code));
      if (got.reason_length !== want.reason_length)
        report($sformatf("reason_length %0d, want %0d",
                         got.reason_length, want.reason_length));
      if (got.headers_offset !== want.headers_offset)
        report($sformatf("headers_offset %0d, want %0d",
                         got.headers_offset, want.headers_offset));
      if (got.headers_length !== want.headers_length)
        report($sformatf("headers_length %0d, want %0d",
                         got.headers_length, want.headers_length));
    endtask
  endclass

endpackage

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// HTTP status line parser testbench
// Streams directed and random response buffers through the parser with random
// gaps on both sides and one long output stall, and checks every result.
// ----------------------------------------------------------------------------

module tb_top;

  import hsp_pkg::*;
  import hsp_tb_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] byte_in
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [0] ok, [10:1] resp_code, [22:11] reason_length,
                                // [35:23] headers_offset, [47:36] headers_length

  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  bit         hold_rx      = 1'b0;
  int         stall_cycles = 0;
  logic [7:0] resp_bytes[$];

  status_line_scoreboard sb = new(MAX_BUFFER_BYTES_DEF);

  http_status_line_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(hsp_result_t'(m_tdata));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("** http_status_line_parser: FAILED **");
    $finish;
  end

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHAR_CR) b = CHAR_SPACE;
    return b;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) resp_bytes.push_back(s[i]);
  endtask

  task automatic add_line_end();
    resp_bytes.push_back(CHAR_CR);
    resp_bytes.push_back(CHAR_LF);
  endtask

  task automatic add_filler(int n, bit text_only);
    repeat (n) resp_bytes.push_back(text_only ? rand_text_byte() : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_response();
    for (int i = 0; i < resp_bytes.size(); i++)
      send_byte(resp_bytes[i], i == resp_bytes.size() - 1);
    resp_bytes.delete();
  endtask

  // Mostly well-formed status lines with random content; the rest noise,
  // a damaged byte, a truncated buffer or a CR without its LF.
  task automatic make_random_response();
    int sel;
    int rlen;
    int cut;
    resp_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      add_filler($urandom_range(1, 20), 1'b0);
      return;
    end
    put_text("HTTP/");
    resp_bytes.push_back(rand_digit());
    resp_bytes.push_back(CHAR_DOT);
    resp_bytes.push_back(rand_digit());
    resp_bytes.push_back(CHAR_SPACE);
    repeat (3) resp_bytes.push_back(rand_digit());
    resp_bytes.push_back(CHAR_SPACE);
    rlen = $urandom_range(0, 8);
    add_filler(rlen, 1'b1);
    add_line_end();
    add_filler($urandom_range(0, 6), 1'b0);
    if (sel < 35) begin
      case ($urandom_range(0, 2))
        0: resp_bytes[$urandom_range(0, 13)] = 8'($urandom_range(0, 255));
        1: begin
          cut = $urandom_range(1, resp_bytes.size());
          resp_bytes = resp_bytes[0:cut-1];
        end
        default: resp_bytes[14 + rlen] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  task automatic run_random(int tx_pct, int rx_pct, int min_items, int min_responses);
    int items;
    int responses;
    items       = 0;
    responses   = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (items < min_items || responses < min_responses) begin
      make_random_response();
      items += resp_bytes.size();
      send_response();
      responses++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 36;
    rx_idle_pct = 78;

    put_text("HTTP/1.1 200 OK"); add_line_end(); send_response();
    put_text("HTTP/1.0 404 Not Found"); add_line_end();
    put_text("Host: a"); add_line_end(); send_response();
    put_text("HTTP/9.9 999 "); add_line_end(); send_response();
    put_text("HTTP/0.0 000 x"); add_line_end(); send_response();
    put_text("H"); send_response();
    put_text("HTTX/1.1 200 OK"); add_line_end(); send_response();
    put_text("HTTP/a.1 200 OK"); add_line_end(); send_response();
    put_text("HTTP/1:1 200 OK"); add_line_end(); send_response();
    put_text("HTTP/1./ 200 OK"); add_line_end(); send_response();
    put_text("HTTP/1.1-200 OK"); add_line_end(); send_response();
    put_text("HTTP/1.1 2x0 OK"); add_line_end(); put_text("A: b"); send_response();
    put_text("HTTP/1.1 20: OK"); add_line_end(); send_response();
    put_text("HTTP/1.1 200-OK"); add_line_end(); send_response();
    // CR not followed by LF fails even with a proper line end later
    put_text("HTTP/1.1 200 OK"); resp_bytes.push_back(CHAR_CR);
    put_text("X"); add_line_end(); send_response();
    put_text("HTTP/1.1 200 OK"); send_response();
    put_text("HTTP/1.1 200 OK"); resp_bytes.push_back(CHAR_CR); send_response();
    put_text("HTTP/1.1 200 "); resp_bytes.push_back(CHAR_CR); send_response();

    run_random(36, 78, 140, 6);
    run_random(78, 36, 140, 6);
    hold_rx = 1'b1;
    run_random(0, 0, 140, 6);
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("** http_status_line_parser: PASSED **");
    else $display("** http_status_line_parser: FAILED **");
    $finish;
  end

endmodule
